/* sv/dnsq_pkg.sv */
// Shared types and constants for the DNS query stream parser.
`timescale 1ns / 1ps

package dnsq_pkg;

  // Header length in bytes and length of the QTYPE/QCLASS tail.
  localparam logic [3:0] HDR_LEN  = 4'd12;
  localparam logic [3:0] TAIL_LEN = 4'd4;

  // Label separator character in the dotted name.
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // Final record status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_QDCOUNT = 2'd1;
  localparam logic [1:0] ST_LABEL   = 2'd2;
  localparam logic [1:0] ST_UNTERM  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAX_LABEL = 1'b0;
  localparam logic CFG_MAX_NAME  = 1'b1;

  typedef struct packed {
    logic [5:0] label_limit;
    logic [7:0] name_limit;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [7:0]  name_index;
    logic [15:0] msg_id;
    logic [15:0] flags_word;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [1:0]  status;
  } result_t;

endpackage

/* sv/dnsq_if.sv */
// Valid/ready channel interfaces for query bytes and parse results.
`timescale 1ns / 1ps

interface dnsq_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface dnsq_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [7:0]  name_index;
  logic [15:0] msg_id;
  logic [15:0] flags_word;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [1:0]  status;

  modport source (
    output valid, output kind, output name_char, output name_index,
    output msg_id, output flags_word, output question_count, output answer_count,
    output authority_count, output additional_count, output query_type,
    output query_class, output status, input ready
  );
  modport sink (
    input valid, input kind, input name_char, input name_index,
    input msg_id, input flags_word, input question_count, input answer_count,
    input authority_count, input additional_count, input query_type,
    input query_class, input status, output ready
  );
endinterface

/* sv/dnsq_core.sv */
// Byte-at-a-time parse state machine for the DNS header and question.
`timescale 1ns / 1ps

module dnsq_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_req,
  input  dnsq_pkg::cfg_t    cfg,
  output logic              emit,
  output dnsq_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_TAIL
  } phase_t;

  phase_t      phase;
  logic [3:0]  byte_pos;
  logic [5:0]  label_left;
  logic [7:0]  name_pos;
  logic [7:0]  name_octets;
  logic        first_len;
  logic [15:0] hdr [6];
  logic [15:0] tail [2];

  phase_t      phase_next;
  logic [3:0]  byte_pos_next;
  logic [5:0]  label_left_next;
  logic [7:0]  name_pos_next;
  logic [7:0]  name_octets_next;
  logic        first_len_next;
  logic [15:0] hdr_next [6];
  logic [15:0] tail_next [2];

  phase_t      ph;
  logic [3:0]  bp;
  logic [5:0]  ll;
  logic [7:0]  np;
  logic [7:0]  octs;
  logic        fl;
  logic [7:0]  limit;
  logic        fin;
  logic [1:0]  fin_status;
  logic        chr_emit;
  logic [7:0]  chr;

  always_comb begin
    // A start mark restarts the message with this byte.
    ph    = start_req ? PH_HEADER : phase;
    bp    = start_req ? 4'd0 : byte_pos;
    ll    = start_req ? 6'd0 : label_left;
    np    = start_req ? 8'd0 : name_pos;
    octs  = start_req ? 8'd0 : name_octets;
    fl    = start_req ? 1'b1 : first_len;
    limit = (cfg.name_limit == 8'd0) ? 8'd1 : cfg.name_limit;

    phase_next       = ph;
    byte_pos_next    = bp;
    label_left_next  = ll;
    name_pos_next    = np;
    name_octets_next = octs;
    first_len_next   = fl;
    hdr_next         = hdr;
    tail_next        = tail;
    fin              = 1'b0;
    fin_status       = dnsq_pkg::ST_OK;
    chr_emit         = 1'b0;
    chr              = 8'd0;

    case (ph)
      PH_HEADER: begin
        if (bp[0]) begin
          hdr_next[bp[3:1]][7:0] = data_byte;
        end else begin
          hdr_next[bp[3:1]][15:8] = data_byte;
        end
        if (bp == dnsq_pkg::HDR_LEN - 4'd1) begin
          byte_pos_next = 4'd0;
          if (hdr_next[2] != 16'd1) begin
            fin        = 1'b1;
            fin_status = dnsq_pkg::ST_QDCOUNT;
          end else begin
            phase_next = PH_NAME;
          end
        end else begin
          byte_pos_next = bp + 4'd1;
        end
      end
      PH_NAME: begin
        name_octets_next = octs + 8'd1;
        if (ll == 6'd0 && data_byte == 8'd0) begin
          phase_next    = PH_TAIL;
          byte_pos_next = 4'd0;
        end else if (name_octets_next >= limit) begin
          fin        = 1'b1;
          fin_status = dnsq_pkg::ST_UNTERM;
        end else if (ll != 6'd0) begin
          label_left_next = ll - 6'd1;
          chr_emit        = 1'b1;
          chr             = data_byte;
        end else if (data_byte > {2'b00, cfg.label_limit}) begin
          fin        = 1'b1;
          fin_status = dnsq_pkg::ST_LABEL;
        end else begin
          // The compare above keeps the length within six bits.
          label_left_next = data_byte[5:0];
          first_len_next  = 1'b0;
          if (!fl) begin
            chr_emit = 1'b1;
            chr      = dnsq_pkg::DOT_CHAR;
          end
        end
      end
      PH_TAIL: begin
        if (bp[0]) begin
          tail_next[bp[1]][7:0] = data_byte;
        end else begin
          tail_next[bp[1]][15:8] = data_byte;
        end
        if (bp == dnsq_pkg::TAIL_LEN - 4'd1) begin
          byte_pos_next = 4'd0;
          fin           = 1'b1;
          fin_status    = dnsq_pkg::ST_OK;
        end else begin
          byte_pos_next = bp + 4'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (chr_emit) begin
      name_pos_next = np + 8'd1;
    end
    if (fin) begin
      phase_next = PH_IDLE;
    end

    emit = chr_emit || fin;
    res  = '0;
    if (fin) begin
      res.kind             = dnsq_pkg::KIND_FINAL;
      res.name_index       = (fin_status == dnsq_pkg::ST_QDCOUNT) ? 8'd0 : np;
      res.msg_id           = hdr_next[0];
      res.flags_word       = hdr_next[1];
      res.question_count   = hdr_next[2];
      res.answer_count     = hdr_next[3];
      res.authority_count  = hdr_next[4];
      res.additional_count = hdr_next[5];
      res.query_type       = (fin_status == dnsq_pkg::ST_OK) ? tail_next[0] : 16'd0;
      res.query_class      = (fin_status == dnsq_pkg::ST_OK) ? tail_next[1] : 16'd0;
      res.status           = fin_status;
    end else begin
      res.kind       = dnsq_pkg::KIND_CHAR;
      res.name_char  = chr;
      res.name_index = np;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_pos    <= 4'd0;
      label_left  <= 6'd0;
      name_pos    <= 8'd0;
      name_octets <= 8'd0;
      first_len   <= 1'b1;
    end else if (accept) begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      label_left  <= label_left_next;
      name_pos    <= name_pos_next;
      name_octets <= name_octets_next;
      first_len   <= first_len_next;
    end
  end

  // Captured header and tail words; every word is fully written before use.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr  <= hdr_next;
      tail <= tail_next;
    end
  end

`ifndef SYNTH
  a_final_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && res.kind == dnsq_pkg::KIND_FINAL) |=> (phase == PH_IDLE))
    else $error("parser did not return to idle after a final record");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (byte_pos < dnsq_pkg::HDR_LEN))
    else $error("header byte position out of range");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && !start_req) |-> !emit)
    else $error("result produced while idle");
`endif

endmodule

/* sv/dnsq_skid.sv */
// Two-entry output buffer that decouples the parser from result backpressure.
`timescale 1ns / 1ps

module dnsq_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dnsq_pkg::result_t push_data,
  output logic              ready,
  output logic              out_valid,
  output dnsq_pkg::result_t out_data,
  input  logic              out_ready
);

  logic              skid_valid;
  dnsq_pkg::result_t skid_data;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("item pushed into a full output buffer");
`endif

endmodule

/* sv/dns_query_stream_parser.sv */
// Top level of the DNS query stream parser.
`timescale 1ns / 1ps

// Parses a DNS query presented one byte per item, with start_req on the first
// byte of each message. The block accepts one byte every clock cycle while
// input ready is high; each byte is handled by the parse state machine in the
// cycle it is accepted, and any result it yields (a dotted-name character or
// the final record) is registered into the two-entry output buffer. It sets the
// only stall: input ready drops when both entries hold results the sink has not
// taken. There is no clearing pass after reset. The label length limit
// (index 0) and the name length limit (index 1) should be written only while
// no message is in flight.
module dns_query_stream_parser (
  input  logic       clk,
  input  logic       rst,
  dnsq_byte_if.sink  query,
  dnsq_result_if.source result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  dnsq_pkg::cfg_t    cfg;
  dnsq_pkg::result_t core_res;
  dnsq_pkg::result_t out_data;
  logic              core_emit;
  logic              accept;
  logic              buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.label_limit <= 6'd63;
      cfg.name_limit  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        dnsq_pkg::CFG_MAX_LABEL: cfg.label_limit <= cfg_data[5:0];
        dnsq_pkg::CFG_MAX_NAME:  cfg.name_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign query.ready = buf_ready;
  assign accept      = query.valid && buf_ready;

  dnsq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (query.data_byte),
    .start_req (query.start_req),
    .cfg       (cfg),
    .emit      (core_emit),
    .res       (core_res)
  );

  dnsq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && core_emit),
    .push_data (core_res),
    .ready     (buf_ready),
    .out_valid (result.valid),
    .out_data  (out_data),
    .out_ready (result.ready)
  );

  assign result.kind             = out_data.kind;
  assign result.name_char        = out_data.name_char;
  assign result.name_index       = out_data.name_index;
  assign result.msg_id           = out_data.msg_id;
  assign result.flags_word       = out_data.flags_word;
  assign result.question_count   = out_data.question_count;
  assign result.answer_count     = out_data.answer_count;
  assign result.authority_count  = out_data.authority_count;
  assign result.additional_count = out_data.additional_count;
  assign result.query_type       = out_data.query_type;
  assign result.query_class      = out_data.query_class;
  assign result.status           = out_data.status;

endmodule
